// File: rtl/sra_pkg.sv
// shared types, codes and sequence helpers for the selective-repeat arq engine
// no dependencies; imported by sra_ctrl, sra_datapath and the top level
`default_nettype none

package sra_pkg;

  localparam int SEQ_MAX = 15;
  localparam int WINDOW  = 8;
  localparam int SEQ_W   = $clog2(SEQ_MAX + 1);
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // event commands
  localparam logic [2:0] CMD_NET_READY = 3'd0;
  localparam logic [2:0] CMD_PHY_READY = 3'd1;
  localparam logic [2:0] CMD_FRAME     = 3'd2;
  localparam logic [2:0] CMD_DATA_TMO  = 3'd3;
  localparam logic [2:0] CMD_ACK_TMO   = 3'd4;

  // received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // result actions
  localparam logic [2:0] ACT_SEND_DATA = 3'd0;
  localparam logic [2:0] ACT_SEND_NAK  = 3'd1;
  localparam logic [2:0] ACT_SEND_ACK  = 3'd2;
  localparam logic [2:0] ACT_DELIVER   = 3'd3;
  localparam logic [2:0] ACT_RELEASE   = 3'd4;
  localparam logic [2:0] ACT_STATUS    = 3'd5;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SEND_NEW,
    OP_LINK_UP,
    OP_SEND_TMO,
    OP_SEND_ACK,
    OP_SEND_NAK,
    OP_MARK,
    OP_DELIVER,
    OP_RESEND,
    OP_RELEASE,
    OP_STATUS
  } dp_op_t;

  // datapath conditions seen by the controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       good;
    logic [1:0] kind;
    logic       win_free;
    logic       nak_allowed;
    logic       seq_unexpected;
    logic       mark_new;
    logic       deliver_rdy;
    logic       resend_ok;
    logic       release_ok;
    logic       out_space;
  } dp_stat_t;

  function automatic seq_t seq_next(input seq_t n);
    return (n == seq_t'(SEQ_MAX)) ? '0 : n + seq_t'(1);
  endfunction

  function automatic seq_t seq_prev(input seq_t n);
    return (n == '0) ? seq_t'(SEQ_MAX) : n - seq_t'(1);
  endfunction

  // b lies in the circular range [a, c)
  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic slot_t slot_of(input seq_t s);
    return slot_t'(s % WINDOW);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sra_ctrl.sv
// event sequencer for the selective-repeat arq engine
// depends on sra_pkg; drives sra_datapath one operation per cycle
`default_nettype none

module sra_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sra_pkg::dp_stat_t stat,
  output sra_pkg::dp_op_t       op
);
  import sra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RX_NAK,
    S_RX_MARK,
    S_DELIVER,
    S_RESEND,
    S_RELEASE,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_NET_READY: begin
            // full window: event ignored
            if (!stat.win_free) begin
              state_nxt = S_STATUS;
            end else if (stat.out_space) begin
              op        = OP_SEND_NEW;
              state_nxt = S_STATUS;
            end
          end
          CMD_PHY_READY: begin
            op        = OP_LINK_UP;
            state_nxt = S_STATUS;
          end
          CMD_FRAME: begin
            if (stat.good) begin
              state_nxt = S_RX_NAK;
            end else if (!stat.nak_allowed) begin
              state_nxt = S_STATUS;
            end else if (stat.out_space) begin
              op        = OP_SEND_NAK;
              state_nxt = S_STATUS;
            end
          end
          CMD_DATA_TMO: begin
            if (stat.out_space) begin
              op        = OP_SEND_TMO;
              state_nxt = S_STATUS;
            end
          end
          CMD_ACK_TMO: begin
            if (stat.out_space) begin
              op        = OP_SEND_ACK;
              state_nxt = S_STATUS;
            end
          end
          default: begin
            state_nxt = S_STATUS;
          end
        endcase
      end
      S_RX_NAK: begin
        if (stat.kind != KIND_DATA) begin
          state_nxt = S_RESEND;
        end else if (!(stat.seq_unexpected && stat.nak_allowed)) begin
          state_nxt = S_RX_MARK;
        end else if (stat.out_space) begin
          op        = OP_SEND_NAK;
          state_nxt = S_RX_MARK;
        end
      end
      S_RX_MARK: begin
        if (stat.mark_new) begin
          op        = OP_MARK;
          state_nxt = S_DELIVER;
        end else begin
          state_nxt = S_RESEND;
        end
      end
      S_DELIVER: begin
        // one in-order delivery per cycle while the output has space, until a gap
        if (!stat.deliver_rdy) begin
          state_nxt = S_RESEND;
        end else if (stat.out_space) begin
          op = OP_DELIVER;
        end
      end
      S_RESEND: begin
        if (!stat.resend_ok) begin
          state_nxt = S_RELEASE;
        end else if (stat.out_space) begin
          op        = OP_RESEND;
          state_nxt = S_RELEASE;
        end
      end
      S_RELEASE: begin
        // one release per cycle while the output has space and the ack covers the window base
        if (!stat.release_ok) begin
          state_nxt = S_STATUS;
        end else if (stat.out_space) begin
          op = OP_RELEASE;
        end
      end
      S_STATUS: begin
        if (stat.out_space) begin
          op        = OP_STATUS;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sra_datapath.sv
// window state, receive bitmap, event latch and output word register
// depends on sra_pkg; operations come from sra_ctrl
`default_nettype none

module sra_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sra_pkg::dp_op_t   op,
  output sra_pkg::dp_stat_t      stat,
  input  wire logic [2:0]        in_command,
  input  wire logic              in_frame_good,
  input  wire logic [1:0]        in_frame_kind,
  input  wire sra_pkg::seq_t     in_frame_seq,
  input  wire sra_pkg::seq_t     in_peer_ack,
  input  wire sra_pkg::seq_t     in_timeout_seq,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_action,
  output sra_pkg::seq_t          out_seq_no,
  output sra_pkg::seq_t          out_ack_no,
  output sra_pkg::slot_t         out_slot,
  output logic                   out_network_enable,
  output logic                   out_last
);
  import sra_pkg::*;

  // latched event
  logic [2:0] ev_cmd_r;
  logic       ev_good_r;
  logic [1:0] ev_kind_r;
  seq_t       ev_seq_r, ev_ack_r, ev_tseq_r;

  // protocol state
  seq_t              send_window_base_r, send_window_base_nxt;
  seq_t              next_send_seq_r, next_send_seq_nxt;
  seq_t              recv_expected_seq_r, recv_expected_seq_nxt;
  seq_t              recv_window_edge_r, recv_window_edge_nxt;
  logic [WINDOW-1:0] arrived_marks_r, arrived_marks_nxt;
  cnt_t              outstanding_count_r, outstanding_count_nxt;
  logic              link_ready_r, link_ready_nxt;
  logic              nak_allowed_r, nak_allowed_nxt;

  // output word
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_action_r, out_action_nxt;
  seq_t       out_seq_no_r, out_seq_no_nxt;
  seq_t       out_ack_no_r, out_ack_no_nxt;
  slot_t      out_slot_r, out_slot_nxt;
  logic       out_en_r, out_en_nxt;
  logic       out_last_r, out_last_nxt;

  logic out_space;
  logic emit;
  seq_t ack_value;
  seq_t resend_seq;
  logic win_free;

  assign out_space  = !out_valid_r || out_ready;
  assign ack_value  = seq_prev(recv_expected_seq_r);
  assign resend_seq = seq_next(ev_ack_r);
  assign win_free   = outstanding_count_r < cnt_t'(WINDOW);

  always_comb begin
    stat.cmd            = ev_cmd_r;
    stat.good           = ev_good_r;
    stat.kind           = ev_kind_r;
    stat.win_free       = win_free;
    stat.nak_allowed    = nak_allowed_r;
    stat.seq_unexpected = ev_seq_r != recv_expected_seq_r;
    stat.mark_new       = in_window(recv_expected_seq_r, ev_seq_r, recv_window_edge_r) &&
                          !arrived_marks_r[slot_of(ev_seq_r)];
    stat.deliver_rdy    = arrived_marks_r[slot_of(recv_expected_seq_r)];
    stat.resend_ok      = (ev_kind_r == KIND_NAK) &&
                          in_window(send_window_base_r, resend_seq, next_send_seq_r);
    stat.release_ok     = in_window(send_window_base_r, ev_ack_r, next_send_seq_r);
    stat.out_space      = out_space;
  end

  always_comb begin
    send_window_base_nxt  = send_window_base_r;
    next_send_seq_nxt     = next_send_seq_r;
    recv_expected_seq_nxt = recv_expected_seq_r;
    recv_window_edge_nxt  = recv_window_edge_r;
    arrived_marks_nxt     = arrived_marks_r;
    outstanding_count_nxt = outstanding_count_r;
    link_ready_nxt        = link_ready_r;
    nak_allowed_nxt       = nak_allowed_r;

    emit           = 1'b0;
    out_action_nxt = out_action_r;
    out_seq_no_nxt = out_seq_no_r;
    out_ack_no_nxt = out_ack_no_r;
    out_slot_nxt   = out_slot_r;
    out_en_nxt     = out_en_r;
    out_last_nxt   = out_last_r;

    case (op)
      OP_SEND_NEW: begin
        emit                  = 1'b1;
        out_action_nxt        = ACT_SEND_DATA;
        out_seq_no_nxt        = next_send_seq_r;
        out_ack_no_nxt        = ack_value;
        out_slot_nxt          = slot_of(next_send_seq_r);
        outstanding_count_nxt = outstanding_count_r + cnt_t'(1);
        next_send_seq_nxt     = seq_next(next_send_seq_r);
        link_ready_nxt        = 1'b0;
      end
      OP_LINK_UP: begin
        link_ready_nxt = 1'b1;
      end
      OP_SEND_TMO: begin
        emit           = 1'b1;
        out_action_nxt = ACT_SEND_DATA;
        out_seq_no_nxt = ev_tseq_r;
        out_ack_no_nxt = ack_value;
        out_slot_nxt   = slot_of(ev_tseq_r);
        link_ready_nxt = 1'b0;
      end
      OP_SEND_ACK: begin
        emit           = 1'b1;
        out_action_nxt = ACT_SEND_ACK;
        out_seq_no_nxt = '0;
        out_ack_no_nxt = ack_value;
        out_slot_nxt   = '0;
        link_ready_nxt = 1'b0;
      end
      OP_SEND_NAK: begin
        emit            = 1'b1;
        out_action_nxt  = ACT_SEND_NAK;
        out_seq_no_nxt  = '0;
        out_ack_no_nxt  = ack_value;
        out_slot_nxt    = '0;
        nak_allowed_nxt = 1'b0;
        link_ready_nxt  = 1'b0;
      end
      OP_MARK: begin
        arrived_marks_nxt[slot_of(ev_seq_r)] = 1'b1;
      end
      OP_DELIVER: begin
        emit                  = 1'b1;
        out_action_nxt        = ACT_DELIVER;
        out_seq_no_nxt        = recv_expected_seq_r;
        out_ack_no_nxt        = '0;
        out_slot_nxt          = slot_of(recv_expected_seq_r);
        nak_allowed_nxt       = 1'b1;
        arrived_marks_nxt[slot_of(recv_expected_seq_r)] = 1'b0;
        recv_expected_seq_nxt = seq_next(recv_expected_seq_r);
        recv_window_edge_nxt  = seq_next(recv_window_edge_r);
      end
      OP_RESEND: begin
        emit           = 1'b1;
        out_action_nxt = ACT_SEND_DATA;
        out_seq_no_nxt = resend_seq;
        out_ack_no_nxt = ack_value;
        out_slot_nxt   = slot_of(resend_seq);
        link_ready_nxt = 1'b0;
      end
      OP_RELEASE: begin
        emit           = 1'b1;
        out_action_nxt = ACT_RELEASE;
        out_seq_no_nxt = send_window_base_r;
        out_ack_no_nxt = '0;
        out_slot_nxt   = slot_of(send_window_base_r);
        if (outstanding_count_r != '0) begin
          outstanding_count_nxt = outstanding_count_r - cnt_t'(1);
        end
        send_window_base_nxt = seq_next(send_window_base_r);
      end
      OP_STATUS: begin
        emit           = 1'b1;
        out_action_nxt = ACT_STATUS;
        out_seq_no_nxt = '0;
        out_ack_no_nxt = '0;
        out_slot_nxt   = '0;
      end
      default: begin
      end
    endcase

    // network_enable and last are only set on the status word
    if (emit) begin
      out_en_nxt   = (op == OP_STATUS) && win_free && link_ready_r;
      out_last_nxt = (op == OP_STATUS);
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_window_base_r  <= '0;
      next_send_seq_r     <= '0;
      recv_expected_seq_r <= '0;
      recv_window_edge_r  <= seq_t'(WINDOW % (SEQ_MAX + 1));
      arrived_marks_r     <= '0;
      outstanding_count_r <= '0;
      link_ready_r        <= 1'b0;
      nak_allowed_r       <= 1'b1;
      out_valid_r         <= 1'b0;
    end else begin
      send_window_base_r  <= send_window_base_nxt;
      next_send_seq_r     <= next_send_seq_nxt;
      recv_expected_seq_r <= recv_expected_seq_nxt;
      recv_window_edge_r  <= recv_window_edge_nxt;
      arrived_marks_r     <= arrived_marks_nxt;
      outstanding_count_r <= outstanding_count_nxt;
      link_ready_r        <= link_ready_nxt;
      nak_allowed_r       <= nak_allowed_nxt;
      out_valid_r         <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LATCH) begin
      ev_cmd_r  <= in_command;
      ev_good_r <= in_frame_good;
      ev_kind_r <= in_frame_kind;
      ev_seq_r  <= in_frame_seq;
      ev_ack_r  <= in_peer_ack;
      ev_tseq_r <= in_timeout_seq;
    end
    out_action_r <= out_action_nxt;
    out_seq_no_r <= out_seq_no_nxt;
    out_ack_no_r <= out_ack_no_nxt;
    out_slot_r   <= out_slot_nxt;
    out_en_r     <= out_en_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_seq_no         = out_seq_no_r;
  assign out_ack_no         = out_ack_no_r;
  assign out_slot           = out_slot_r;
  assign out_network_enable = out_en_r;
  assign out_last           = out_last_r;

  a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_count_r <= cnt_t'(WINDOW))
    else $error("outstanding count above window size");

  a_outstanding_tracks_window: assert property (@(posedge clk) disable iff (!rst_n)
    seq_t'(next_send_seq_r - send_window_base_r) == seq_t'(outstanding_count_r))
    else $error("outstanding count out of step with send window");

  a_recv_edge_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    recv_window_edge_r == seq_t'(recv_expected_seq_r + seq_t'(WINDOW)))
    else $error("receive window edge out of step with expected seq");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_space)
    else $error("output word overwritten while still pending");

  a_deliver_clears_mark: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_DELIVER |=> !arrived_marks_r[$past(slot_of(recv_expected_seq_r))])
    else $error("delivered slot still marked");

endmodule

`default_nettype wire

// File: rtl/selective_repeat_arq_engine.sv
// channel  | handshake          | payload
// in_      | in_valid/in_ready  | command, frame_good, frame_kind, frame_seq, peer_ack,
//          |                    | timeout_seq
// out_     | out_valid/out_ready| action, seq_no, ack_no, slot, network_enable, last
//
// one event is taken at a time; after acceptance the sequencer makes its decisions and
// emits its words in turn until the status word is loaded,
// the longest path being 8 deliveries plus 8 releases.
// a stalled out_ready holds the sequencer at the next word; in_ready rises again as
// soon as the status word sits in the output register.
// synchronous active-low reset puts both windows at their start, link down, nak allowed.
// depends on sra_pkg, sra_ctrl and sra_datapath
`default_nettype none

module selective_repeat_arq_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     in_command,
  input  wire logic           in_frame_good,
  input  wire logic [1:0]     in_frame_kind,
  input  wire sra_pkg::seq_t  in_frame_seq,
  input  wire sra_pkg::seq_t  in_peer_ack,
  input  wire sra_pkg::seq_t  in_timeout_seq,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          out_action,
  output sra_pkg::seq_t       out_seq_no,
  output sra_pkg::seq_t       out_ack_no,
  output sra_pkg::slot_t      out_slot,
  output logic                out_network_enable,
  output logic                out_last
);
  import sra_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  sra_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .stat               (stat),
    .in_command         (in_command),
    .in_frame_good      (in_frame_good),
    .in_frame_kind      (in_frame_kind),
    .in_frame_seq       (in_frame_seq),
    .in_peer_ack        (in_peer_ack),
    .in_timeout_seq     (in_timeout_seq),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_seq_no         (out_seq_no),
    .out_ack_no         (out_ack_no),
    .out_slot           (out_slot),
    .out_network_enable (out_network_enable),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
